// ===== rtl/prun_pkg.sv =====
// ----------------------------------------------------------------------------
// prun_pkg
// Shared constants for the page run allocator: tag bits, action codes, config indices and defaults.
// ----------------------------------------------------------------------------
package prun_pkg;

	localparam int TagW          = 4;
	localparam int NumPagesDef   = 1024;

	localparam logic [TagW-1:0] TAG_FREE   = 4'h0;
	localparam logic [TagW-1:0] TAG_USED   = 4'h1;
	localparam logic [TagW-1:0] TAG_EXTENT = 4'h2;
	localparam logic [TagW-1:0] TAG_SLAB   = 4'h4;
	localparam logic [TagW-1:0] TAG_GC     = 4'h8;

	localparam logic [1:0] ACT_ALLOC  = 2'd0;
	localparam logic [1:0] ACT_FREE   = 2'd1;
	localparam logic [1:0] ACT_EXTEND = 2'd2;
	localparam logic [1:0] ACT_REINIT = 2'd3;

	localparam logic CFG_RESERVED  = 1'b0;
	localparam logic CFG_WATERMARK = 1'b1;

	localparam logic [6:0] RESERVED_RST  = 7'd1;
	localparam logic [9:0] WATERMARK_RST = 10'd256;

endpackage

// ===== rtl/page_run_allocator.sv =====
// ----------------------------------------------------------------------------
// page_run_allocator
// First-fit allocator of contiguous page runs over a tag table in memory.
// ----------------------------------------------------------------------------
// Input channel (in_valid/in_ready) carries one request transaction: allocate,
// free, extend watermark or reinitialize. Output channel (out_valid/out_ready)
// returns exactly one result transaction per request. One request is worked on
// at a time; in_ready is high only while the sequencer is idle.
// Extend, a zero-count allocate and an out-of-range free go straight to the
// result; a free of a page that is not a used head ends after its tag read.
// Allocate reads the tags of each candidate run, starting from the hint, from
// the single tag memory, whose read data is registered; it restarts the fit
// check after a blocked page and then writes each page of the run.
// Free reads the head tag, clears it, then clears each extent page after it,
// stopping at a page without the extent tag or at the watermark.
// Reinitialize makes a full pass over the table.
// After reset the block runs the same pass over the table, writing
// every tag, and accepts no request until it ends. Configuration writes are
// taken at any time and act at the next table rebuild.
// A result waits in the output register while the receiver stalls; the
// sequencer holds in its done state until that register is free.
// ----------------------------------------------------------------------------
module page_run_allocator #(
	parameter int NUM_PAGES = prun_pkg::NumPagesDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [9:0]  cfg_data,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  action,
	input  logic [10:0] page_count,
	input  logic        slab_mark,
	input  logic        collectible_mark,
	input  logic [9:0]  page_index,
	input  logic [10:0] extend_pages,
	output logic        out_valid,
	input  logic        out_ready,
	output logic        ok,
	output logic [9:0]  start_page,
	output logic [10:0] pages_in_use,
	output logic [10:0] usable_limit
);
	import prun_pkg::*;

	localparam int PW = $clog2(NUM_PAGES);
	localparam int CW = PW + 1;
	localparam int SW = ((CW > 11) ? CW : 11) + 1;
	localparam logic [SW-1:0] N_S   = SW'(NUM_PAGES);
	localparam logic [SW-1:0] NM1_S = SW'(NUM_PAGES - 1);
	localparam logic [SW-1:0] NM2_S = SW'(NUM_PAGES - 2);

	typedef enum logic [9:0] {
		S_LOAD  = 10'b0000000001,
		S_INIT  = 10'b0000000010,
		S_IDLE  = 10'b0000000100,
		S_AFIT  = 10'b0000001000,
		S_ARD   = 10'b0000010000,
		S_ACHK  = 10'b0000100000,
		S_AWR   = 10'b0001000000,
		S_FCHK  = 10'b0010000000,
		S_XNEXT = 10'b0100000000,
		S_DONE  = 10'b1000000000
	} state_t;

	state_t state_q;

	logic [6:0]    resv_cfg_q;
	logic [9:0]    wm_cfg_q;
	logic [CW-1:0] wm_q, hint_q, used_q, resv_q, ptr_q, head_q;
	logic [SW-1:0] cnt_q, end_q;
	logic [TagW-1:0] attr_q;
	logic          single_q, report_q, ok_q;
	logic [CW-1:0] start_q;
	// high while a free walks the extent pages after its head
	logic          xchk_q;

	logic          ram_we;
	logic [PW-1:0] ram_waddr;
	logic [TagW-1:0] ram_wdata, ram_rdata;

	logic [SW-1:0] r_clamp, w_clamp, ext_sum, ptr_inc_s;

	prun_tag_ram #(.NUM_PAGES(NUM_PAGES)) u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ptr_q[PW-1:0]),
		.rdata (ram_rdata)
	);

	always_comb begin
		r_clamp = SW'(resv_cfg_q);
		if (r_clamp > NM2_S) r_clamp = NM2_S;
		w_clamp = SW'(wm_cfg_q);
		if (w_clamp < r_clamp + SW'(1)) w_clamp = r_clamp + SW'(1);
		if (w_clamp > NM1_S) w_clamp = NM1_S;
		ext_sum = SW'(wm_q) + SW'(extend_pages);
		if (ext_sum > N_S) ext_sum = N_S;
		ptr_inc_s = SW'(ptr_q) + SW'(1);
	end

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = ptr_q[PW-1:0];
		ram_wdata = TAG_FREE;
		unique case (state_q)
			S_INIT: begin
				ram_we    = 1'b1;
				ram_wdata = (ptr_q < resv_q) ? TAG_USED : TAG_FREE;
			end
			S_AWR: begin
				ram_we    = 1'b1;
				ram_wdata = ((ptr_q == head_q) ? TAG_USED : TAG_EXTENT) | attr_q;
			end
			S_FCHK: ram_we = xchk_q ? ((ram_rdata & TAG_EXTENT) != TAG_FREE) :
				((ram_rdata & TAG_USED) != TAG_FREE);
			S_XNEXT: ram_we = 1'b0;
			default: ram_we = 1'b0;
		endcase
	end

	assign in_ready = (state_q == S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			resv_cfg_q <= RESERVED_RST;
			wm_cfg_q   <= WATERMARK_RST;
		end else if (cfg_we) begin
			if (cfg_index == CFG_RESERVED) resv_cfg_q <= cfg_data[6:0];
			else                           wm_cfg_q   <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_LOAD;
			report_q     <= 1'b0;
			xchk_q       <= 1'b0;
			out_valid    <= 1'b0;
			wm_q         <= '0;
			hint_q       <= '0;
			used_q       <= '0;
			resv_q       <= '0;
			ptr_q        <= '0;
			head_q       <= '0;
			cnt_q        <= '0;
			end_q        <= '0;
			attr_q       <= TAG_FREE;
			single_q     <= 1'b0;
			ok_q         <= 1'b0;
			start_q      <= '0;
			ok           <= 1'b0;
			start_page   <= '0;
			pages_in_use <= '0;
			usable_limit <= '0;
		end else begin
			if (out_valid && out_ready && state_q != S_DONE) out_valid <= 1'b0;
			unique case (state_q)
				S_LOAD: begin
					resv_q  <= CW'(r_clamp);
					wm_q    <= CW'(w_clamp);
					hint_q  <= '0;
					used_q  <= '0;
					ptr_q   <= '0;
					state_q <= S_INIT;
				end
				S_INIT: begin
					ptr_q <= ptr_q + CW'(1);
					if (ptr_q == CW'(NUM_PAGES - 1)) begin
						ok_q    <= 1'b1;
						state_q <= report_q ? S_DONE : S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_valid) begin
						ok_q    <= 1'b0;
						start_q <= '0;
						unique case (action)
							ACT_ALLOC: begin
								cnt_q    <= SW'(page_count);
								single_q <= (page_count == 11'd1);
								attr_q   <= (slab_mark ? TAG_SLAB : TAG_FREE) |
									((slab_mark && collectible_mark &&
									  page_count == 11'd1) ? TAG_GC : TAG_FREE);
								head_q   <= hint_q;
								state_q  <= (page_count == 11'd0) ? S_DONE : S_AFIT;
							end
							ACT_FREE: begin
								ptr_q <= CW'(page_index);
								// a zero count marks the read as part of a free
								cnt_q <= '0;
								if (SW'(page_index) < SW'(wm_q) &&
									SW'(page_index) >= SW'(resv_q)) begin
									state_q <= S_ARD;
									xchk_q  <= 1'b0;
								end else begin
									state_q <= S_DONE;
								end
							end
							ACT_EXTEND: begin
								if (wm_q != CW'(NUM_PAGES)) begin
									wm_q <= CW'(ext_sum);
									ok_q <= 1'b1;
								end
								state_q <= S_DONE;
							end
							ACT_REINIT: begin
								report_q <= 1'b1;
								state_q  <= S_LOAD;
							end
							default: state_q <= S_DONE;
						endcase
					end
				end
				S_AFIT: begin
					// fail once the candidate run no longer fits under the watermark
					end_q <= SW'(head_q) + cnt_q;
					ptr_q <= head_q;
					if (SW'(head_q) + cnt_q > SW'(wm_q)) state_q <= S_DONE;
					else                                 state_q <= S_ARD;
				end
				S_ARD: begin
					// wait for the tag read of ptr_q
					state_q <= (cnt_q == '0) ? S_FCHK : S_ACHK;
				end
				S_ACHK: begin
					if (ram_rdata != TAG_FREE) begin
						head_q  <= CW'(ptr_inc_s);
						state_q <= S_AFIT;
					end else if (ptr_inc_s == end_q) begin
						ptr_q   <= head_q;
						state_q <= S_AWR;
					end else begin
						ptr_q   <= CW'(ptr_inc_s);
						state_q <= S_ARD;
					end
				end
				S_AWR: begin
					ptr_q <= CW'(ptr_inc_s);
					if (ptr_inc_s == end_q) begin
						used_q  <= CW'(SW'(used_q) + cnt_q);
						if (single_q) hint_q <= CW'(SW'(head_q) + SW'(1));
						ok_q    <= 1'b1;
						start_q <= head_q;
						state_q <= S_DONE;
					end
				end
				S_FCHK: begin
					if (!xchk_q) begin
						if ((ram_rdata & TAG_USED) != TAG_FREE) begin
							if (ptr_q < hint_q) hint_q <= ptr_q;
							if (used_q != '0) used_q <= used_q - CW'(1);
							ptr_q   <= CW'(ptr_inc_s);
							xchk_q  <= 1'b1;
							state_q <= S_XNEXT;
						end else begin
							state_q <= S_DONE;
						end
					end else if ((ram_rdata & TAG_EXTENT) != TAG_FREE) begin
						if (used_q != '0) used_q <= used_q - CW'(1);
						ptr_q   <= CW'(ptr_inc_s);
						state_q <= S_XNEXT;
					end else begin
						ok_q    <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_XNEXT: begin
					if (ptr_q < wm_q) begin
						state_q <= S_FCHK;
					end else begin
						ok_q    <= 1'b1;
						state_q <= S_DONE;
					end
				end
				S_DONE: begin
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						ok           <= ok_q;
						start_page   <= 10'(start_q);
						pages_in_use <= 11'(used_q);
						usable_limit <= 11'(wm_q);
						report_q     <= 1'b0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

// ===== rtl/prun_tag_ram.sv =====
// ----------------------------------------------------------------------------
// prun_tag_ram
// Page tag table: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module prun_tag_ram #(
	parameter int NUM_PAGES = prun_pkg::NumPagesDef
) (
	input  logic                         clk,
	input  logic                         we,
	input  logic [$clog2(NUM_PAGES)-1:0] waddr,
	input  logic [prun_pkg::TagW-1:0]    wdata,
	input  logic [$clog2(NUM_PAGES)-1:0] raddr,
	output logic [prun_pkg::TagW-1:0]    rdata
);
	import prun_pkg::*;

	logic [TagW-1:0] mem [NUM_PAGES];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem[raddr];
	end

endmodule
